[rtl/core/tscc_pkg.sv]
`timescale 1ns / 1ps

package tscc_pkg;

	// pointer id space
	localparam int MaxPointers = 32;
	localparam int IdWidth     = $clog2(MaxPointers);

	// field widths
	localparam int ActionWidth  = 4;
	localparam int DeviceWidth  = 16;
	localparam int SourceWidth  = 32;
	localparam int CountWidth   = 6;
	localparam int IndexWidth   = 6;
	localparam int HistWidth    = 16;
	localparam int ProblemWidth = 12;

	// reset value of the pointer class mask
	localparam logic [SourceWidth-1:0] PointerClassReset = 32'd2;

	typedef logic [ActionWidth-1:0]  action_t;
	typedef logic [MaxPointers-1:0]  ptr_mask_t;
	typedef logic [ProblemWidth-1:0] problem_t;

	// action codes
	localparam action_t ActDown      = 4'd0;
	localparam action_t ActUp        = 4'd1;
	localparam action_t ActMove      = 4'd2;
	localparam action_t ActCancel    = 4'd3;
	localparam action_t ActOutside   = 4'd4;
	localparam action_t ActPtrDown   = 4'd5;
	localparam action_t ActPtrUp     = 4'd6;
	localparam action_t ActUnhandled = 4'd7;

	// problem bit positions
	localparam int PrbMultiSource = 0;
	localparam int PrbDownWhileDn = 1;
	localparam int PrbHistory     = 2;
	localparam int PrbCountNotOne = 3;
	localparam int PrbMoveCount   = 4;
	localparam int PrbOutsideDown = 5;
	localparam int PrbPtrDnAlone  = 6;
	localparam int PrbBadIndex    = 7;
	localparam int PrbIdAlready   = 8;
	localparam int PrbIdNotDown   = 9;
	localparam int PrbBadAction   = 10;
	localparam int PrbNotPointer  = 11;

	// one input request as held in the input register
	typedef struct packed {
		action_t                action;
		logic [DeviceWidth-1:0] device_id;
		logic [SourceWidth-1:0] source_bits;
		logic [CountWidth-1:0]  pointer_count;
		logic [IndexWidth-1:0]  action_index;
		logic [IdWidth-1:0]     pointer_id;
		logic [HistWidth-1:0]   history_size;
	} event_t;

endpackage

[rtl/core/touch_stream_consistency_checker_unit.sv]
`timescale 1ns / 1ps

// Touch stream consistency checker.
// Input channel: in_valid / in_stall with one touch event (or an unhandled
// notice) per request. Output channel: out_valid / out_stall with one result
// per request: problem_mask, mark_tainted and the pointer mask after the event.
// Configuration: cfg_valid / cfg_ready writes the pointer class mask; cfg_ready
// is always high, and writes are expected only while the block is idle.
// An accepted request is captured in the input register, checked against the
// stream state by combinational logic, and its result moves to the output
// register once that register is empty or no longer stalled.
// Throughput: one request per cycle while out_stall is low; the stream state
// and result registers update together, so the next request sees it at once.
// Reset clears the stream state, empties both registers and sets the pointer
// class mask to 2. When the receiver stalls, the result holds in the output
// register, one more request waits in the input register, and in_stall is
// raised once both are full.
module touch_stream_consistency_checker_unit
	import tscc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [SourceWidth-1:0]  cfg_data,
	// input requests
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [ActionWidth-1:0]  action,
	input  logic [DeviceWidth-1:0]  device_id,
	input  logic [SourceWidth-1:0]  source_bits,
	input  logic [CountWidth-1:0]   pointer_count,
	input  logic signed [IndexWidth-1:0] action_index,
	input  logic [IdWidth-1:0]      pointer_id,
	input  logic [HistWidth-1:0]    history_size,
	// results
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [ProblemWidth-1:0] problem_mask,
	output logic                    mark_tainted,
	output logic [MaxPointers-1:0]  pointers_down
);

	localparam int PopWidth = $clog2(MaxPointers + 1);

	// configuration and stream state
	logic [SourceWidth-1:0] ptr_class_q;
	ptr_mask_t              down_mask_q;
	logic                   tainted_q;
	logic                   unhandled_q;
	logic                   dev_valid_q;
	logic [DeviceWidth-1:0] last_dev_q;
	logic [SourceWidth-1:0] last_src_q;

	// pipeline registers
	logic      valid_s1;
	event_t    ev_s1;
	logic      valid_s2;
	problem_t  prob_s2;
	logic      mark_s2;
	ptr_mask_t down_s2;

	logic adv_s1;
	logic take_in;

	// combinational results for the event in the input register
	problem_t  prob_c;
	logic      mark_c;
	ptr_mask_t down_c;
	logic      taint_c;
	logic      unh_c;
	logic      new_stream;
	ptr_mask_t base_mask;
	logic      base_taint;
	logic      id_ok;
	ptr_mask_t id_bit;
	logic      idx_bad;
	logic      hist_nz;
	logic      count_n1;
	logic [PopWidth-1:0] pop;

	// handshakes
	assign cfg_ready = 1'b1;
	assign adv_s1    = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !adv_s1;
	assign take_in   = in_valid && !in_stall;

	assign out_valid     = valid_s2;
	assign problem_mask  = prob_s2;
	assign mark_tainted  = mark_s2;
	assign pointers_down = down_s2;

	// popcount of the current pointer mask
	always_comb begin
		pop = '0;
		for (int i = 0; i < MaxPointers; i++) begin
			pop = pop + PopWidth'(down_mask_q[i]);
		end
	end

	// per-event checks
	always_comb begin
		new_stream = (ev_s1.action == ActDown) || (ev_s1.action == ActCancel)
			|| (ev_s1.action == ActOutside);
		id_ok   = ({1'b0, ev_s1.pointer_id} < (IdWidth + 1)'(MaxPointers));
		id_bit  = id_ok ? (ptr_mask_t'(1) << ev_s1.pointer_id) : '0;
		idx_bad = ev_s1.action_index[IndexWidth-1]
			|| (ev_s1.action_index >= ev_s1.pointer_count) || !id_ok;
		hist_nz  = (ev_s1.history_size != '0);
		count_n1 = (ev_s1.pointer_count != CountWidth'(1));

		// a new stream clears a tainted or unhandled one
		if (new_stream && (tainted_q || unhandled_q)) begin
			base_mask  = '0;
			base_taint = 1'b0;
			unh_c      = 1'b0;
		end else begin
			base_mask  = down_mask_q;
			base_taint = tainted_q;
			unh_c      = unhandled_q;
		end
		mark_c  = base_taint;
		down_c  = base_mask;
		taint_c = base_taint;
		prob_c  = '0;

		if (!new_stream && dev_valid_q
			&& (last_dev_q != ev_s1.device_id || last_src_q != ev_s1.source_bits)) begin
			prob_c[PrbMultiSource] = 1'b1;
		end

		if ((ev_s1.source_bits & ptr_class_q) != '0) begin
			case (ev_s1.action)
				ActDown: begin
					prob_c[PrbDownWhileDn] = (base_mask != '0);
					prob_c[PrbHistory]     = hist_nz;
					prob_c[PrbCountNotOne] = count_n1;
					down_c = id_bit;
				end
				ActUp: begin
					prob_c[PrbHistory]     = hist_nz;
					prob_c[PrbCountNotOne] = count_n1;
					down_c  = '0;
					taint_c = 1'b0;
				end
				ActMove: begin
					if ({1'b0, ev_s1.pointer_count} != (CountWidth + 1)'(pop)) begin
						prob_c[PrbMoveCount] = 1'b1;
						taint_c = 1'b1;
					end
				end
				ActCancel: begin
					down_c  = '0;
					taint_c = 1'b0;
				end
				ActOutside: begin
					prob_c[PrbOutsideDown] = (base_mask != '0);
					prob_c[PrbHistory]     = hist_nz;
					prob_c[PrbCountNotOne] = count_n1;
					taint_c = 1'b0;
				end
				ActPtrDown: begin
					if (base_mask == '0) begin
						prob_c[PrbPtrDnAlone] = 1'b1;
						taint_c = 1'b1;
					end
					if (idx_bad) begin
						prob_c[PrbBadIndex] = 1'b1;
						taint_c = 1'b1;
					end else if ((base_mask & id_bit) != '0) begin
						prob_c[PrbIdAlready] = 1'b1;
						taint_c = 1'b1;
					end else begin
						down_c = base_mask | id_bit;
					end
					prob_c[PrbHistory] = hist_nz;
				end
				ActPtrUp: begin
					if (idx_bad) begin
						prob_c[PrbBadIndex] = 1'b1;
						taint_c = 1'b1;
					end else if ((base_mask & id_bit) == '0) begin
						prob_c[PrbIdNotDown] = 1'b1;
						taint_c = 1'b1;
					end else begin
						down_c = base_mask & ~id_bit;
					end
					prob_c[PrbHistory] = hist_nz;
				end
				default: begin
					prob_c[PrbBadAction] = 1'b1;
				end
			endcase
		end else begin
			prob_c[PrbNotPointer] = 1'b1;
		end

		// unhandled notice only raises the flag
		if (ev_s1.action == ActUnhandled) begin
			prob_c  = '0;
			mark_c  = tainted_q;
			down_c  = down_mask_q;
			taint_c = tainted_q;
			unh_c   = 1'b1;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_class_q <= PointerClassReset;
		end else if (cfg_valid && cfg_ready) begin
			ptr_class_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1 || !valid_s1) begin
			valid_s1 <= take_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			ev_s1 <= '{action: action, device_id: device_id, source_bits: source_bits,
				pointer_count: pointer_count, action_index: action_index,
				pointer_id: pointer_id, history_size: history_size};
		end
	end

	// stream state update as the request moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_mask_q <= '0;
			tainted_q   <= 1'b0;
			unhandled_q <= 1'b0;
			dev_valid_q <= 1'b0;
			last_dev_q  <= '0;
			last_src_q  <= '0;
		end else if (valid_s1 && adv_s1) begin
			down_mask_q <= down_c;
			tainted_q   <= taint_c;
			unhandled_q <= unh_c;
			if (ev_s1.action != ActUnhandled) begin
				dev_valid_q <= 1'b1;
				last_dev_q  <= ev_s1.device_id;
				last_src_q  <= ev_s1.source_bits;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			prob_s2 <= prob_c;
			mark_s2 <= mark_c;
			down_s2 <= down_c;
		end
	end

endmodule

[bench/touch_stream_consistency_checker_unit_tb.sv]
`timescale 1ns / 1ps

module touch_stream_consistency_checker_unit_tb;
	import tscc_pkg::*;

	// action codes outside the touch set
	localparam action_t ActOther   = 4'd8;
	localparam action_t ActTopCode = 4'd15;

	// extreme and typical pointer class settings
	localparam logic [SourceWidth-1:0] ClassAll  = 32'hFFFF_FFFF;
	localparam logic [SourceWidth-1:0] ClassNone = 32'h0000_0000;
	localparam logic [SourceWidth-1:0] ClassTop  = 32'h8000_0000;

	// one expected result
	typedef struct {
		problem_t  problem;
		logic      taint;
		ptr_mask_t ptrs;
	} verdict_t;

	// gesture rule tracker: predicts each result and checks the block against it
	class stream_rule_tracker;
		ptr_mask_t              down_ids;
		bit                     tainted;
		bit                     unhandled;
		bit                     dev_seen;
		logic [DeviceWidth-1:0] last_dev;
		logic [SourceWidth-1:0] last_src;
		logic [SourceWidth-1:0] class_mask;
		verdict_t               pending_verdicts[$];
		int                     faults;

		function new();
			down_ids   = '0;
			tainted    = 1'b0;
			unhandled  = 1'b0;
			dev_seen   = 1'b0;
			last_dev   = '0;
			last_src   = '0;
			class_mask = PointerClassReset;
			faults     = 0;
		endfunction

		function void note_fault(string msg);
			faults++;
			if (faults <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		// apply one accepted request to the tracked stream state
		function void log_event(event_t ev);
			verdict_t  v;
			problem_t  prob;
			bit        fresh;
			bit        id_ok;
			int        idx;
			int        cnt;
			ptr_mask_t id_bit;

			prob   = '0;
			idx    = int'($signed(ev.action_index));
			cnt    = int'(ev.pointer_count);
			id_ok  = int'(ev.pointer_id) < MaxPointers;
			id_bit = id_ok ? (ptr_mask_t'(1) << ev.pointer_id) : '0;

			// unhandled notice only flags the stream
			if (ev.action == ActUnhandled) begin
				unhandled = 1'b1;
				v.problem = '0;
				v.taint   = tainted;
				v.ptrs    = down_ids;
				pending_verdicts.push_back(v);
				return;
			end

			// new stream drops a tainted or unhandled one
			fresh = ev.action == ActDown || ev.action == ActCancel || ev.action == ActOutside;
			if (fresh && (tainted || unhandled)) begin
				tainted   = 1'b0;
				unhandled = 1'b0;
				down_ids  = '0;
			end
			v.taint = tainted;

			// device or source change inside a stream
			if (!fresh && dev_seen && (last_dev != ev.device_id || last_src != ev.source_bits))
				prob[PrbMultiSource] = 1'b1;
			last_dev = ev.device_id;
			last_src = ev.source_bits;
			dev_seen = 1'b1;

			if ((ev.source_bits & class_mask) != '0) begin
				case (ev.action)
					ActDown: begin
						if (down_ids != '0) prob[PrbDownWhileDn] = 1'b1;
						if (ev.history_size != '0) prob[PrbHistory] = 1'b1;
						if (cnt != 1) prob[PrbCountNotOne] = 1'b1;
						down_ids = id_bit;
					end
					ActUp: begin
						if (ev.history_size != '0) prob[PrbHistory] = 1'b1;
						if (cnt != 1) prob[PrbCountNotOne] = 1'b1;
						down_ids = '0;
						tainted  = 1'b0;
					end
					ActMove: begin
						if (cnt != $countones(down_ids)) begin
							prob[PrbMoveCount] = 1'b1;
							tainted = 1'b1;
						end
					end
					ActCancel: begin
						down_ids = '0;
						tainted  = 1'b0;
					end
					ActOutside: begin
						if (down_ids != '0) prob[PrbOutsideDown] = 1'b1;
						if (ev.history_size != '0) prob[PrbHistory] = 1'b1;
						if (cnt != 1) prob[PrbCountNotOne] = 1'b1;
						tainted = 1'b0;
					end
					ActPtrDown: begin
						if (down_ids == '0) begin
							prob[PrbPtrDnAlone] = 1'b1;
							tainted = 1'b1;
						end
						if (idx < 0 || idx >= cnt || !id_ok) begin
							prob[PrbBadIndex] = 1'b1;
							tainted = 1'b1;
						end else if ((down_ids & id_bit) != '0) begin
							prob[PrbIdAlready] = 1'b1;
							tainted = 1'b1;
						end else begin
							down_ids |= id_bit;
						end
						if (ev.history_size != '0) prob[PrbHistory] = 1'b1;
					end
					ActPtrUp: begin
						if (idx < 0 || idx >= cnt || !id_ok) begin
							prob[PrbBadIndex] = 1'b1;
							tainted = 1'b1;
						end else if ((down_ids & id_bit) == '0) begin
							prob[PrbIdNotDown] = 1'b1;
							tainted = 1'b1;
						end else begin
							down_ids &= ~id_bit;
						end
						if (ev.history_size != '0) prob[PrbHistory] = 1'b1;
					end
					default: begin
						prob[PrbBadAction] = 1'b1;
					end
				endcase
			end else begin
				prob[PrbNotPointer] = 1'b1;
			end

			v.problem = prob;
			v.ptrs    = down_ids;
			pending_verdicts.push_back(v);
		endfunction

		// compare one accepted result with the oldest expectation
		function void compare_result(problem_t prob, logic taint, ptr_mask_t ptrs);
			verdict_t v;
			if (pending_verdicts.size() == 0) begin
				note_fault($sformatf("result with none pending: problem %03h taint %0b ptrs %08h",
					prob, taint, ptrs));
				return;
			end
			v = pending_verdicts.pop_front();
			if (prob !== v.problem || taint !== v.taint || ptrs !== v.ptrs)
				note_fault($sformatf(
					"mismatch: problem %03h/%03h taint %0b/%0b ptrs %08h/%08h (exp/act)",
					v.problem, prob, v.taint, taint, v.ptrs, ptrs));
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [SourceWidth-1:0]  cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic [ActionWidth-1:0]  action;
	logic [DeviceWidth-1:0]  device_id;
	logic [SourceWidth-1:0]  source_bits;
	logic [CountWidth-1:0]   pointer_count;
	logic signed [IndexWidth-1:0] action_index;
	logic [IdWidth-1:0]      pointer_id;
	logic [HistWidth-1:0]    history_size;
	logic                    out_valid;
	logic                    out_stall;
	logic [ProblemWidth-1:0] problem_mask;
	logic                    mark_tainted;
	logic [MaxPointers-1:0]  pointers_down;

	stream_rule_tracker      tracker;
	logic [SourceWidth-1:0]  class_mask;
	int                      events_sent;
	bit                      in_quiet;
	bit                      out_quiet;

	touch_stream_consistency_checker_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.device_id    (device_id),
		.source_bits  (source_bits),
		.pointer_count(pointer_count),
		.action_index (action_index),
		.pointer_id   (pointer_id),
		.history_size (history_size),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.problem_mask (problem_mask),
		.mark_tainted (mark_tainted),
		.pointers_down(pointers_down)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("touch_stream_consistency_checker_unit_tb: errors");
		$finish;
	end

	// present one request and hold it until accepted
	task automatic push_event(input event_t ev);
		int gap;
		gap = in_quiet ? 0 : $urandom_range(0, 7);
		if ($urandom_range(0, 39) == 0)
			in_quiet = !in_quiet;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		action        <= ev.action;
		device_id     <= ev.device_id;
		source_bits   <= ev.source_bits;
		pointer_count <= ev.pointer_count;
		action_index  <= ev.action_index;
		pointer_id    <= ev.pointer_id;
		history_size  <= ev.history_size;
		do @(posedge clk); while (in_stall);
		tracker.log_event(ev);
		events_sent++;
	endtask

	task automatic send(input action_t act, input logic [DeviceWidth-1:0] dev,
			input logic [SourceWidth-1:0] src, input int cnt, input int idx,
			input int pid, input int hist);
		event_t ev;
		ev.action        = act;
		ev.device_id     = dev;
		ev.source_bits   = src;
		ev.pointer_count = CountWidth'(cnt);
		ev.action_index  = IndexWidth'(idx);
		ev.pointer_id    = IdWidth'(pid);
		ev.history_size  = HistWidth'(hist);
		push_event(ev);
	endtask

	// fully random request, any action code and field value
	task automatic send_noise();
		event_t ev;
		ev.action        = ActionWidth'($urandom_range(0, 15));
		ev.device_id     = DeviceWidth'($urandom);
		ev.source_bits   = $urandom_range(0, 1) ? $urandom : pointer_source();
		ev.pointer_count = CountWidth'($urandom);
		ev.action_index  = IndexWidth'($urandom);
		ev.pointer_id    = IdWidth'($urandom);
		ev.history_size  = $urandom_range(0, 1) ? '0 : HistWidth'($urandom);
		push_event(ev);
	endtask

	// random source that hits the pointer class when any class bit is set
	function automatic logic [SourceWidth-1:0] pointer_source();
		int b;
		if (class_mask == '0)
			return $urandom;
		do b = $urandom_range(0, SourceWidth - 1); while (!class_mask[b]);
		return $urandom | (32'd1 << b);
	endfunction

	// write the class mask once the block has drained
	task automatic write_class_mask(input logic [SourceWidth-1:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		tracker.class_mask = value;
		class_mask = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one mostly well-formed gesture with occasional faults
	task automatic play_gesture();
		logic [DeviceWidth-1:0] dev;
		logic [SourceWidth-1:0] src;
		ptr_mask_t              held;
		int                     id;
		int                     cnt;
		int                     steps;
		int                     pick;
		dev   = DeviceWidth'($urandom);
		src   = pointer_source();
		id    = $urandom_range(0, MaxPointers - 1);
		held  = ptr_mask_t'(1) << id;
		send(ActDown, dev, src, 1, 0, id, 0);
		steps = $urandom_range(1, 12);
		repeat (steps) begin
			pick = $urandom_range(0, 9);
			cnt  = $countones(held);
			if (pick >= 4 && pick <= 5 && cnt < MaxPointers) begin
				do id = $urandom_range(0, MaxPointers - 1); while (held[id]);
				send(ActPtrDown, dev, src, cnt + 1, $urandom_range(0, cnt), id, 0);
				held[id] = 1'b1;
			end else if (pick >= 6 && pick <= 7 && cnt > 1) begin
				do id = $urandom_range(0, MaxPointers - 1); while (!held[id]);
				send(ActPtrUp, dev, src, cnt, $urandom_range(0, cnt - 1), id, 0);
				held[id] = 1'b0;
			end else if (pick == 8) begin
				send(ActUnhandled, dev, src, cnt, 0, 0, 0);
			end else if (pick == 9) begin
				// injected fault
				case ($urandom_range(0, 4))
					0: send(ActMove, dev, src, (cnt + $urandom_range(1, 5)) % 64, 0, 0, 0);
					1: begin
						dev = DeviceWidth'($urandom);
						send(ActMove, dev, src, cnt, 0, 0, 0);
					end
					2: begin
						do id = $urandom_range(0, MaxPointers - 1); while (!held[id]);
						send(ActPtrDown, dev, src, cnt + 1, 0, id, $urandom_range(1, 65535));
					end
					3: send(ActPtrUp, dev, src, cnt, $urandom_range(0, 1) ? cnt : -1,
						$urandom_range(0, MaxPointers - 1), 0);
					default: send_noise();
				endcase
			end else begin
				send(ActMove, dev, src, cnt, $urandom, $urandom, $urandom);
			end
		end
		pick = $urandom_range(0, 9);
		if (pick < 7)
			send(ActUp, dev, src, 1, 0, 0, 0);
		else if (pick < 9)
			send(ActCancel, dev, src, $urandom_range(0, 63), 0, 0, 0);
	endtask

	task automatic run_mix(input int count);
		int stop_at;
		stop_at = events_sent + count;
		while (events_sent < stop_at) begin
			if ($urandom_range(0, 3) != 0)
				play_gesture();
			else
				send_noise();
		end
	endtask

	// result side: random stalls, then accept and check one result
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = out_quiet ? 0 : $urandom_range(0, 7);
			if ($urandom_range(0, 39) == 0)
				out_quiet = !out_quiet;
			@(negedge clk);
			out_stall <= (hold != 0);
			if (hold != 0) begin
				repeat (hold) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			tracker.compare_result(problem_mask, mark_tainted, pointers_down);
		end
	end

	// reset, directed requests, random phases across class settings
	initial begin
		tracker       = new();
		class_mask    = PointerClassReset;
		events_sent   = 0;
		in_quiet      = 1'b0;
		out_quiet     = 1'b0;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		action        = '0;
		device_id     = '0;
		source_bits   = '0;
		pointer_count = '0;
		action_index  = '0;
		pointer_id    = '0;
		history_size  = '0;
		out_stall     = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: every action and rule with the reset class mask
		send(ActUnhandled, 16'd0, 32'd0, 0, 0, 0, 0);
		send(ActDown, 16'd1, 32'd2, 1, 0, 0, 0);
		send(ActMove, 16'd1, 32'd2, 1, 0, 0, 0);
		send(ActPtrDown, 16'd1, 32'd2, 2, 1, 31, 0);
		send(ActMove, 16'd1, 32'd2, 2, 0, 0, 0);
		send(ActPtrDown, 16'd1, 32'd2, 2, 0, 31, 0);
		send(ActMove, 16'd1, 32'd2, 5, 0, 0, 0);
		send(ActPtrUp, 16'd1, 32'd2, 2, 0, 7, 0);
		send(ActPtrUp, 16'd1, 32'd2, 2, -1, 0, 0);
		send(ActPtrUp, 16'd1, 32'd2, 2, 2, 0, 0);
		send(ActUp, 16'd1, 32'd2, 0, 0, 0, 65535);
		send(ActPtrDown, 16'd1, 32'd2, 32, 31, 5, 1);
		send(ActMove, 16'd65535, 32'd2, 1, 0, 0, 0);
		send(ActMove, 16'd65535, 32'hFFFF_FFFF, 1, 0, 0, 0);
		send(ActUnhandled, 16'd65535, 32'hFFFF_FFFF, 0, 0, 0, 0);
		send(ActDown, 16'd2, 32'd2, 1, 0, 3, 0);
		send(ActDown, 16'd2, 32'd2, 1, 0, 4, 0);
		send(ActOutside, 16'd2, 32'd2, 32, 0, 0, 65535);
		send(ActCancel, 16'd2, 32'd2, 63, -32, 31, 65535);
		send(ActOther, 16'd2, 32'd2, 1, 0, 0, 0);
		send(ActTopCode, 16'd2, 32'd2, 63, 31, 31, 65535);
		send(ActMove, 16'd2, 32'hFFFF_FFFD, 0, 0, 0, 0);
		send(ActDown, 16'd3, 32'd2, 63, 31, 0, 0);
		send(ActPtrDown, 16'd3, 32'd2, 63, -32, 9, 0);
		send(ActOther, 16'd0, 32'd0, 0, 0, 0, 0);

		// random phases over several class settings
		write_class_mask(ClassAll);
		run_mix(300);
		write_class_mask(ClassNone);
		run_mix(60);
		write_class_mask($urandom);
		run_mix(300);
		write_class_mask(PointerClassReset);
		run_mix(350);
		write_class_mask(ClassTop);
		run_mix(300);

		// drain and settle
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending_verdicts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		tracker.faults += tracker.pending_verdicts.size();
		if (tracker.faults == 0)
			$display("touch_stream_consistency_checker_unit_tb: clean");
		else
			$display("touch_stream_consistency_checker_unit_tb: errors");
		$finish;
	end

endmodule

[touch_stream_consistency_checker_unit.f]
rtl/core/tscc_pkg.sv
rtl/core/touch_stream_consistency_checker_unit.sv
bench/touch_stream_consistency_checker_unit_tb.sv
